// File: hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes and helpers of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int POOL_PAGES_DEFAULT  = 16;
   localparam int IDX_W               = 9;
   localparam int TABLE_DEPTH_DEFAULT = POOL_PAGES_DEFAULT << IDX_W;

   localparam int ENTRY_W    = 52;
   localparam int VA_W       = 48;
   localparam int FLAGS_W    = 12;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int PAGE_SHIFT = 12;

   localparam logic [ENTRY_W-1:0] OFFSET_MASK = 52'hfff;
   localparam logic [ENTRY_W-1:0] PRESENT_BIT = 52'h1;
   localparam logic [ENTRY_W-1:0] LINK_BITS   = 52'h7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_MAP    = 2'd1,
      ACT_UNMAP  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_MISSING   = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_ZERO,
      S_LINK,
      S_DONE
   } state_type;

   function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] level);
      logic [IDX_W-1:0] idx;
      case (level)
         2'd0: begin
            idx = va[47:39];
         end
         2'd1: begin
            idx = va[38:30];
         end
         2'd2: begin
            idx = va[29:21];
         end
         default: begin
            idx = va[20:12];
         end
      endcase
      return idx;
   endfunction

endpackage

// File: hdl/ptw_channels.sv
// ----------------------------------------------------------------------------
// ptw_channels
// Valid/ready channels of the page table walker: request, response, csr.
// ----------------------------------------------------------------------------
interface ptw_req_if;
   import ptw_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VA_W-1:0]     virt_addr;
   logic [ENTRY_W-1:0]  phys_addr;
   logic [FLAGS_W-1:0]  page_flags;
   modport source (output valid, action, virt_addr, phys_addr, page_flags, input ready);
   modport sink   (input valid, action, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface ptw_rsp_if;
   import ptw_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  leaf_entry;
   modport source (output valid, status, leaf_entry, input ready);
   modport sink   (input valid, status, leaf_entry, output ready);
endinterface

interface ptw_csr_if;
   import ptw_pkg::*;
   logic               valid;
   logic               ready;
   logic [ENTRY_W-1:0] table_base;
   modport source (output valid, table_base, input ready);
   modport sink   (input valid, table_base, output ready);
endinterface

// File: hdl/ptw_table_ram.sv
// ----------------------------------------------------------------------------
// ptw_table_ram
// Single-port table entry memory, registered read; no read in a write cycle.
// ----------------------------------------------------------------------------
module ptw_table_ram #(
   parameter int DEPTH = ptw_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   input  logic [ptw_pkg::ENTRY_W-1:0] wr_data,
   output logic [ptw_pkg::ENTRY_W-1:0] rd_data
);
   import ptw_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/page_table_map_walker_core.sv
// ----------------------------------------------------------------------------
// page_table_map_walker_core
// Four-level radix page table walk with lookup, map and unmap over a bump
// allocated pool of table pages held in one single-port memory.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | accepted
//  req_if   | in  | action, virt_addr, phys_addr, page_flags     | valid & ready
//  rsp_if   | out | status, leaf_entry                           | valid & ready
//  csr_if   | in  | table_base                                   | valid & ready
//
//  A request that walks all four levels is accepted in S_IDLE, then takes
//  four read/evaluate pairs (S_READ, S_EVAL) on the table memory port and
//  the hand-off in S_DONE, which loads the response register. A walk that
//  stops early skips the read/evaluate pairs of the levels below it.
//  Each table that a map allocates adds a clear of its 512 entries (S_ZERO)
//  and a write of the link entry (S_LINK), all through the same memory port.
//  After reset a clearing pass zeroes all POOL_PAGES*512 entries (8192 by
//  default) before the first request; csr writes are taken during it.
//  The response register lets a new request be taken while a response waits.
// ----------------------------------------------------------------------------
module page_table_map_walker_core #(
   parameter int POOL_PAGES = ptw_pkg::POOL_PAGES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req_if,
   ptw_rsp_if.source rsp_if,
   ptw_csr_if.sink   csr_if
);
   import ptw_pkg::*;

   localparam int PG_W   = $clog2(POOL_PAGES);
   localparam int DEPTH  = POOL_PAGES << IDX_W;
   localparam int ADDR_W = PG_W + IDX_W;
   localparam int NF_W   = $clog2(POOL_PAGES + 1);
   localparam int PN_W   = ENTRY_W - PAGE_SHIFT;

   state_type state_ff, state_in;
   logic [1:0]          level_ff, level_in;
   logic [PG_W-1:0]     page_ff, page_in;
   logic [PG_W-1:0]     fresh_ff, fresh_in;
   logic [NF_W-1:0]     next_free_ff, next_free_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic [ENTRY_W-1:0]  pa_ff, pa_in;
   logic [FLAGS_W-1:0]  flags_ff, flags_in;
   logic [ENTRY_W-1:0]  base_ff, base_in;
   status_type res_status_ff, res_status_in;
   logic [ENTRY_W-1:0]  res_leaf_ff, res_leaf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0]  rsp_leaf_ff, rsp_leaf_in;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic [ENTRY_W-1:0]  rd_data;

   logic [ADDR_W-1:0]   slot_addr;
   logic [ENTRY_W-1:0]  entry_diff;
   logic [ENTRY_W-1:0]  link_entry;
   logic [ENTRY_W-1:0]  map_leaf;
   logic                entry_present;
   logic                entry_in_pool;
   logic                pool_full;
   logic                last_level;
   logic                is_map;
   logic                rsp_free;

   ptw_table_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (rd_data)
   );

   assign slot_addr     = {page_ff, table_index(va_ff, level_ff)};
   assign entry_present = rd_data[0];
   assign entry_diff    = (rd_data & ~OFFSET_MASK) - base_ff;
   assign entry_in_pool = entry_diff[ENTRY_W-1:PAGE_SHIFT] < PN_W'(POOL_PAGES);
   assign pool_full     = next_free_ff >= NF_W'(POOL_PAGES);
   assign link_entry    = (base_ff + (ENTRY_W'(fresh_ff) << PAGE_SHIFT)) | LINK_BITS;
   assign map_leaf      = (pa_ff & ~OFFSET_MASK) | ENTRY_W'(flags_ff) | PRESENT_BIT;
   assign last_level    = level_ff == 2'd3;
   assign is_map        = action_ff == ACT_MAP;
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (cnt_ff == ADDR_W'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_if.valid) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (last_level) begin
               state_in = S_DONE;
            end else if (entry_present) begin
               state_in = entry_in_pool ? S_READ : S_DONE;
            end else if (is_map && !pool_full) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ZERO: begin
            if (cnt_ff[IDX_W-1:0] == '1) state_in = S_LINK;
         end
         S_LINK: begin
            state_in = S_READ;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      level_in      = level_ff;
      page_in       = page_ff;
      fresh_in      = fresh_ff;
      next_free_in  = next_free_ff;
      cnt_in        = cnt_ff;
      action_in     = action_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      flags_in      = flags_ff;
      base_in       = base_ff;
      res_status_in = res_status_ff;
      res_leaf_in   = res_leaf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_leaf_in   = rsp_leaf_ff;
      mem_we        = 1'b0;
      mem_addr      = slot_addr;
      mem_wdata     = '0;

      if (csr_if.valid) base_in = csr_if.table_base & ~OFFSET_MASK;

      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = cnt_ff;
            cnt_in   = cnt_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_if.valid) begin
               action_in = req_if.action;
               va_in     = req_if.virt_addr;
               pa_in     = req_if.phys_addr;
               flags_in  = req_if.page_flags;
               level_in  = 2'd0;
               page_in   = '0;
            end
         end
         S_EVAL: begin
            res_leaf_in = '0;
            if (last_level) begin
               case (action_ff)
                  ACT_MAP: begin
                     mem_we        = 1'b1;
                     mem_wdata     = map_leaf;
                     res_status_in = ST_OK;
                     res_leaf_in   = map_leaf;
                  end
                  ACT_UNMAP: begin
                     if (entry_present) begin
                        mem_we        = 1'b1;
                        res_status_in = ST_OK;
                     end else begin
                        res_status_in = ST_MISSING;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                     res_leaf_in   = rd_data;
                  end
               endcase
            end else if (entry_present) begin
               if (entry_in_pool) begin
                  page_in  = entry_diff[PAGE_SHIFT +: PG_W];
                  level_in = level_ff + 2'd1;
               end else begin
                  res_status_in = ST_MISSING;
               end
            end else if (is_map) begin
               if (pool_full) begin
                  res_status_in = ST_EXHAUSTED;
               end else begin
                  fresh_in     = next_free_ff[PG_W-1:0];
                  next_free_in = next_free_ff + 1'b1;
                  cnt_in       = '0;
               end
            end else begin
               res_status_in = ST_MISSING;
            end
         end
         S_ZERO: begin
            mem_we   = 1'b1;
            mem_addr = {fresh_ff, cnt_ff[IDX_W-1:0]};
            cnt_in   = cnt_ff + 1'b1;
         end
         S_LINK: begin
            mem_we    = 1'b1;
            mem_wdata = link_entry;
            page_in   = fresh_ff;
            level_in  = level_ff + 2'd1;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_leaf_in   = res_leaf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         next_free_ff <= NF_W'(1);
         cnt_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      page_ff       <= page_in;
      fresh_ff      <= fresh_in;
      action_ff     <= action_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      flags_ff      <= flags_in;
      res_status_ff <= res_status_in;
      res_leaf_ff   <= res_leaf_in;
      rsp_status_ff <= rsp_status_in;
      rsp_leaf_ff   <= rsp_leaf_in;
   end

   assign req_if.ready      = state_ff == S_IDLE;
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.leaf_entry = rsp_leaf_ff;

   a_alloc_bumps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && !last_level && !entry_present && is_map && !pool_full)
      |=> next_free_ff == NF_W'($past(next_free_ff) + 1'b1))
      else $error("pool counter did not advance on allocation");

   a_zero_to_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ZERO && cnt_ff[IDX_W-1:0] == '1) |=> state_ff == S_LINK)
      else $error("page clear did not end in link write");

   a_exhausted_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EXHAUSTED) |-> next_free_ff == NF_W'(POOL_PAGES))
      else $error("pool exhausted reported with free pages left");

   a_error_zero_leaf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_leaf_ff == '0)
      else $error("failed request returned a nonzero leaf");

endmodule

// File: tb/page_table_map_walker_core_tb.sv
// ----------------------------------------------------------------------------
// page_table_map_walker_core_tb
// Self-checking bench for the four-level page table walker. A shadow copy
// of the table pool predicts each response not typed in the directed list,
// which covers the fresh pool, leaf edge values, unmap of absent pages and
// pool exhaustion. Random lookup, map and unmap requests follow, over several
// table bases, with random idle cycles on the request and response sides.
// ----------------------------------------------------------------------------
module page_table_map_walker_core_tb;
   import ptw_pkg::*;

   localparam int POOL          = POOL_PAGES_DEFAULT;
   localparam int TABLE_ENTRIES = 1 << IDX_W;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int MAX_REPORTS   = 40;

   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
   localparam logic [ENTRY_W-1:0]  BASE_TOP     = 52'hF_FFFF_FFFF_F000;
   localparam logic [ENTRY_W-1:0]  BASE_LOW2    = 52'hF_FFFF_FFFF_D000;
   localparam logic [ENTRY_W-1:0]  ALL_ONES     = 52'hF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VA_W-1:0]     va;
      logic [ENTRY_W-1:0]  pa;
      logic [FLAGS_W-1:0]  flags;
   } req_item_type;

   typedef struct packed {
      status_type         st;
      logic [ENTRY_W-1:0] leaf;
   } walk_result_type;

   typedef struct packed {
      req_item_type    rq;
      bit              typed_in;
      walk_result_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   ptw_req_if req_ch();
   ptw_rsp_if rsp_ch();
   ptw_csr_if csr_ch();

   page_table_map_walker_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #2 clock = ~clock;

   // shadow of the table pool
   logic [ENTRY_W-1:0] shadow_tables [POOL*TABLE_ENTRIES];
   int                 shadow_next_page;
   logic [ENTRY_W-1:0] shadow_base;

   walk_result_type    expected_walks [$];
   logic [VA_W-1:0]    mapped_vas [$];
   bit                 quiet_phase;
   int                 mismatches;
   int                 sent_count;
   int                 checked_count;
   int                 base_writes;
   int                 status_tally [3];

   function automatic int idle_draw();
      return quiet_phase ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic logic [ENTRY_W-1:0] rand_entry();
      return ENTRY_W'({$urandom, $urandom});
   endfunction

   function automatic logic [VA_W-1:0] va_of(input int l0, l1, l2, l3);
      return {IDX_W'(l0), IDX_W'(l1), IDX_W'(l2), IDX_W'(l3), 12'h000};
   endfunction

   function automatic void walk_tables(input logic [VA_W-1:0] va, input bit grow,
                                       output status_type st, output int slot);
      logic [ENTRY_W-1:0] link;
      logic [ENTRY_W-1:0] offset;
      logic [ENTRY_W-1:0] pnum;
      int                 page;
      int                 idx;
      page = 0;
      slot = 0;
      st   = ST_OK;
      for (int lvl = 0; lvl < 3; lvl++) begin
         idx  = page * TABLE_ENTRIES + va[47 - IDX_W*lvl -: IDX_W];
         link = shadow_tables[idx];
         if (!link[0]) begin
            if (!grow) begin
               st = ST_MISSING;
               return;
            end
            if (shadow_next_page >= POOL) begin
               st = ST_EXHAUSTED;
               return;
            end
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
               shadow_tables[shadow_next_page*TABLE_ENTRIES + k] = '0;
            end
            pnum = ENTRY_W'(shadow_next_page);
            link = (shadow_base + (pnum << PAGE_SHIFT)) | LINK_BITS;
            shadow_tables[idx] = link;
            shadow_next_page++;
         end
         offset = (link & ~OFFSET_MASK) - shadow_base;
         if (offset[ENTRY_W-1:PAGE_SHIFT] >= POOL) begin
            st = ST_MISSING;
            return;
         end
         page = int'(offset[ENTRY_W-1:PAGE_SHIFT]);
      end
      slot = page * TABLE_ENTRIES + va[20:12];
   endfunction

   function automatic void predict_walk(input req_item_type rq,
                                        output walk_result_type res);
      status_type         st;
      int                 slot;
      logic [ENTRY_W-1:0] leaf;
      leaf = '0;
      if (rq.action == ACT_MAP) begin
         walk_tables(rq.va, 1'b1, st, slot);
         if (st == ST_OK) begin
            leaf = {rq.pa[ENTRY_W-1:PAGE_SHIFT], rq.flags} | PRESENT_BIT;
            shadow_tables[slot] = leaf;
            mapped_vas.push_back(rq.va);
         end
      end else if (rq.action == ACT_UNMAP) begin
         walk_tables(rq.va, 1'b0, st, slot);
         if (st == ST_OK) begin
            if (!shadow_tables[slot][0]) begin
               st = ST_MISSING;
            end else begin
               shadow_tables[slot] = '0;
            end
         end
      end else begin
         walk_tables(rq.va, 1'b0, st, slot);
         if (st == ST_OK) begin
            leaf = shadow_tables[slot];
         end
      end
      res.st   = st;
      res.leaf = (st == ST_OK) ? leaf : '0;
   endfunction

   function automatic req_item_type random_request();
      req_item_type rq;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         rq.action = ACT_MAP;
      end else if (pick < 65) begin
         rq.action = ACT_LOOKUP;
      end else if (pick < 90) begin
         rq.action = ACT_UNMAP;
      end else begin
         rq.action = ACT_RESERVED;
      end
      rq.pa    = rand_entry();
      rq.flags = FLAGS_W'($urandom);
      pick = $urandom_range(0, 99);
      if (mapped_vas.size() == 0 || pick < 20) begin
         rq.va = VA_W'({$urandom, $urandom});
      end else begin
         // reuse a built path; sometimes steer the leaf index
         rq.va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
         if (pick < 40) begin
            rq.va[20:12] = IDX_W'($urandom_range(0, 7));
         end else if (pick < 55) begin
            rq.va[20:12] = IDX_W'($urandom);
         end
         rq.va[11:0] = PAGE_SHIFT'($urandom);
      end
      return rq;
   endfunction

   function automatic dir_row_type mk_row(input logic [ACTION_W-1:0] act,
                                          input logic [VA_W-1:0] va,
                                          input logic [ENTRY_W-1:0] pa,
                                          input logic [FLAGS_W-1:0] flags,
                                          input int typed_in,
                                          input status_type st,
                                          input logic [ENTRY_W-1:0] leaf);
      dir_row_type r;
      r.rq.action  = act;
      r.rq.va      = va;
      r.rq.pa      = pa;
      r.rq.flags   = flags;
      r.typed_in   = (typed_in != 0);
      r.want.st    = st;
      r.want.leaf  = leaf;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                                  input logic [ENTRY_W-1:0] want);
      if (mismatches < MAX_REPORTS) begin
         $display("ERROR t=%0t response %0d %s: got %h expected %h",
                  $time, checked_count, what, got, want);
      end
      mismatches++;
   endtask

   // called at a falling edge, returns at the falling edge after the request
   task automatic send_request(input req_item_type rq, input bit typed_in,
                               input walk_result_type typed);
      walk_result_type res;
      int              gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= rq.action;
      req_ch.virt_addr  <= rq.va;
      req_ch.phys_addr  <= rq.pa;
      req_ch.page_flags <= rq.flags;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_walk(rq, res);
      expected_walks.push_back(typed_in ? typed : res);
      sent_count++;
      @(negedge clock);
   endtask

   // called at a falling edge with no request in flight
   task automatic write_table_base(input logic [ENTRY_W-1:0] value);
      csr_ch.valid      <= 1'b1;
      csr_ch.table_base <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      shadow_base = value & ~OFFSET_MASK;
      base_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : rsp_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_rsp
      walk_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_walks.size() == 0) begin
            report_mismatch("no request outstanding", rsp_ch.leaf_entry, '0);
         end else begin
            want = expected_walks.pop_front();
            if (rsp_ch.status !== want.st) begin
               report_mismatch("status", ENTRY_W'(rsp_ch.status), ENTRY_W'(want.st));
            end
            if (rsp_ch.leaf_entry !== want.leaf) begin
               report_mismatch("leaf_entry", rsp_ch.leaf_entry, want.leaf);
            end
            if (want.st <= ST_EXHAUSTED) begin
               status_tally[want.st]++;
            end
         end
         checked_count++;
      end
   end

   initial begin : stimulus
      dir_row_type        steps [$];
      logic [ENTRY_W-1:0] phase_base [PHASES];
      logic [FLAGS_W-1:0] low_junk;
      int                 directed_count;

      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_LOOKUP;
      req_ch.virt_addr  = '0;
      req_ch.phys_addr  = '0;
      req_ch.page_flags = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.table_base = '0;
      quiet_phase       = 1'b0;
      mismatches        = 0;
      sent_count        = 0;
      checked_count     = 0;
      base_writes       = 0;
      status_tally      = '{0, 0, 0};
      shadow_next_page  = 1;
      shadow_base       = '0;
      foreach (shadow_tables[i]) shadow_tables[i] = '0;

      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // top of the address space: pool page 1 wraps to address 0
      write_table_base(BASE_TOP | 52'hABC);

      steps.push_back(mk_row(ACT_LOOKUP, va_of(0, 0, 0, 0), '0, '0, 1, ST_MISSING, '0));
      steps.push_back(mk_row(ACT_UNMAP, va_of(0, 0, 0, 0), '0, '0, 1, ST_MISSING, '0));
      steps.push_back(mk_row(ACT_RESERVED, 48'hFFFF_FFFF_FFFF, ALL_ONES, 12'hFFF,
                             1, ST_MISSING, '0));
      steps.push_back(mk_row(ACT_MAP, va_of(0, 0, 0, 0), ALL_ONES, 12'hFFF,
                             1, ST_OK, ALL_ONES));
      steps.push_back(mk_row(ACT_LOOKUP, va_of(0, 0, 0, 0) | 48'hFFF, '0, '0,
                             1, ST_OK, ALL_ONES));
      steps.push_back(mk_row(ACT_MAP, va_of(0, 0, 0, 1), '0, '0, 1, ST_OK, 52'h1));
      steps.push_back(mk_row(ACT_LOOKUP, va_of(0, 0, 0, 1), '0, '0, 1, ST_OK, 52'h1));
      steps.push_back(mk_row(ACT_UNMAP, va_of(0, 0, 0, 1), '0, '0, 1, ST_OK, '0));
      steps.push_back(mk_row(ACT_UNMAP, va_of(0, 0, 0, 1), '0, '0, 1, ST_MISSING, '0));
      steps.push_back(mk_row(ACT_LOOKUP, va_of(0, 0, 0, 1), '0, '0, 1, ST_OK, '0));
      steps.push_back(mk_row(ACT_MAP, 48'hFFFF_FFFF_FFFF, 52'h8_0000_0000_0ABC, 12'h800,
                             1, ST_OK, 52'h8_0000_0000_0801));
      steps.push_back(mk_row(ACT_RESERVED, 48'hFFFF_FFFF_FFFF, '0, '0,
                             1, ST_OK, 52'h8_0000_0000_0801));
      steps.push_back(mk_row(ACT_MAP, va_of(0, 1, 0, 5), rand_entry(), FLAGS_W'($urandom),
                             0, ST_OK, '0));
      steps.push_back(mk_row(ACT_MAP, va_of(1, 0, 0, 0), rand_entry(), FLAGS_W'($urandom),
                             0, ST_OK, '0));
      steps.push_back(mk_row(ACT_MAP, va_of(2, 9'h1FF, 0, 9'h1FF), rand_entry(),
                             FLAGS_W'($urandom), 0, ST_OK, '0));
      // pool runs dry partway through this walk; the level-two table stays
      steps.push_back(mk_row(ACT_MAP, va_of(3, 0, 0, 0), ALL_ONES, 12'h5A5,
                             1, ST_EXHAUSTED, '0));
      steps.push_back(mk_row(ACT_LOOKUP, va_of(3, 0, 0, 0), '0, '0, 1, ST_MISSING, '0));
      steps.push_back(mk_row(ACT_MAP, va_of(3, 0, 0, 0), ALL_ONES, 12'h5A5,
                             1, ST_EXHAUSTED, '0));
      steps.push_back(mk_row(ACT_MAP, va_of(4, 7, 7, 7), ALL_ONES, 12'h0F0,
                             1, ST_EXHAUSTED, '0));
      steps.push_back(mk_row(ACT_UNMAP, va_of(0, 0, 0, 0), '0, '0, 0, ST_OK, '0));
      steps.push_back(mk_row(ACT_LOOKUP, va_of(0, 1, 0, 5), '0, '0, 0, ST_OK, '0));
      steps.push_back(mk_row(ACT_MAP, va_of(0, 0, 0, 0), rand_entry(), FLAGS_W'($urandom),
                             0, ST_OK, '0));
      steps.push_back(mk_row(ACT_LOOKUP, va_of(1, 0, 0, 0), '0, '0, 0, ST_OK, '0));
      steps.push_back(mk_row(ACT_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0, 0, ST_OK, '0));

      foreach (steps[i]) begin
         send_request(steps[i].rq, steps[i].typed_in, steps[i].want);
      end
      directed_count = sent_count;

      // shifted bases make old links decode to other or no pool pages
      phase_base[0] = BASE_TOP;
      phase_base[1] = BASE_TOP;
      phase_base[2] = '0;
      phase_base[3] = rand_entry();
      phase_base[4] = BASE_TOP;
      phase_base[5] = BASE_LOW2;
      phase_base[6] = rand_entry();
      phase_base[7] = BASE_TOP;

      for (int ph = 0; ph < PHASES; ph++) begin
         req_ch.valid <= 1'b0;
         while (expected_walks.size() != 0) @(negedge clock);
         low_junk = FLAGS_W'($urandom);
         write_table_base({phase_base[ph][ENTRY_W-1:PAGE_SHIFT], low_junk});
         quiet_phase = (ph == 1 || ph == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_request(), 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_walks.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      $display("Sent %0d requests (%0d directed) over %0d table base writes.",
               sent_count, directed_count, base_writes);
      $display("Checked %0d responses: %0d ok, %0d missing, %0d pool exhausted.",
               checked_count, status_tally[ST_OK], status_tally[ST_MISSING],
               status_tally[ST_EXHAUSTED]);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d responses outstanding", expected_walks.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
hdl/ptw_pkg.sv
hdl/ptw_channels.sv
hdl/ptw_table_ram.sv
hdl/page_table_map_walker_core.sv
tb/page_table_map_walker_core_tb.sv
